[sv/hse_pkg.sv]
// Shared definitions for the Hermite segment evaluator: default fraction
// width, result status codes and 64-bit saturation limits.
// No dependencies.
package hse_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_ZERO_INTERVAL = 2'd1,
    STATUS_SATURATED     = 2'd2
  } status_t;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

endpackage

[sv/hse_mulq.sv]
// Pipelined signed 64 x 64 fixed-point multiplier: rounds half away from zero
// at FRAC_BITS, saturates to 64 bits and carries a sideband word alongside.
// Depends on hse_pkg.
module hse_mulq #(
  parameter int unsigned FRAC_BITS = hse_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [63:0]       in_a,
  input  logic signed [63:0]       in_b,
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_vld,
  output logic signed [63:0]       out_p,
  output logic                     out_sat,
  output logic        [SIDE_W-1:0] out_side
);

  localparam int unsigned STAGES = 5;
  localparam int unsigned HI_W   = 64 - FRAC_BITS;
  localparam logic [127:0] RND   = 128'd1 << (FRAC_BITS - 1);

  logic              vld_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];
  logic [STAGES-2:0] neg_r;

  // Stage 1: magnitudes.
  logic [63:0] a_neg, b_neg;
  logic [63:0] ua_r, ub_r;
  // Stage 2: 32 x 32 partial products.
  logic [63:0] ll_nxt, lh_nxt, hl_nxt, hh_nxt;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  // Stage 3: the two middle products summed.
  logic [64:0] mid_r;
  logic [63:0] ll3_r, hh3_r;
  // Stage 4: full product with the rounding constant added.
  logic [127:0] prod_nxt, prod_r;
  // Stage 5: shift, saturate, sign.
  logic [HI_W-1:0]   hi_part;
  logic [63:0]       lo_part;
  logic [63:0]       lim;
  logic              sat_nxt;
  logic signed [63:0] p_nxt;
  logic signed [63:0] p_r;
  logic              sat_r;

  assign a_neg = 64'(-in_a);
  assign b_neg = 64'(-in_b);

  assign ll_nxt = ua_r[31:0]  * ub_r[31:0];
  assign lh_nxt = ua_r[31:0]  * ub_r[63:32];
  assign hl_nxt = ua_r[63:32] * ub_r[31:0];
  assign hh_nxt = ua_r[63:32] * ub_r[63:32];

  assign prod_nxt = {hh3_r, ll3_r} + {31'd0, mid_r, 32'd0} + RND;

  always_comb begin
    hi_part = prod_r[127:64+FRAC_BITS];
    lo_part = prod_r[63+FRAC_BITS:FRAC_BITS];
    lim     = neg_r[STAGES-2] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat_nxt = (|hi_part) || (lo_part > lim);
    if (sat_nxt) begin
      p_nxt = neg_r[STAGES-2] ? hse_pkg::S64_MIN : hse_pkg::S64_MAX;
    end else if (neg_r[STAGES-2]) begin
      p_nxt = -$signed(lo_part);
    end else begin
      p_nxt = $signed(lo_part);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 1; i < STAGES; i++) side_r[i] <= side_r[i-1];
    neg_r <= {neg_r[STAGES-3:0], in_a[63] ^ in_b[63]};
    ua_r  <= in_a[63] ? a_neg : in_a;
    ub_r  <= in_b[63] ? b_neg : in_b;
    ll_r  <= ll_nxt;
    lh_r  <= lh_nxt;
    hl_r  <= hl_nxt;
    hh_r  <= hh_nxt;
    mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
    ll3_r <= ll_r;
    hh3_r <= hh_r;
    prod_r <= prod_nxt;
    p_r    <= p_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_side = side_r[STAGES-1];
  assign out_p    = p_r;
  assign out_sat  = sat_r;

endmodule

[sv/hermite_segment_evaluate.sv]
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------
// input    | in_query_time .. in_end_in_slope        | taken when start && !busy
// result   | out_curve_value, out_status             | out_valid, one cycle each
//
// One word is taken every cycle; busy is high only while reset is applied.
// Each word runs through the restoring divider of 32 + FRAC_BITS stages and the
// five-stage multipliers, of which one pair and then three in series are passed.
// Reset is synchronous and clears only the valid bits; words in flight are lost.
// The receiver cannot stall, so the pipeline never holds.
// Depends on hse_pkg and hse_mulq.
module hermite_segment_evaluate #(
  parameter int unsigned FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_query_time,
  input  logic signed [31:0] in_start_time,
  input  logic signed [31:0] in_start_value,
  input  logic signed [31:0] in_start_out_slope,
  input  logic signed [31:0] in_end_time,
  input  logic signed [31:0] in_end_value,
  input  logic signed [31:0] in_end_in_slope,
  output logic               out_valid,
  output logic signed [31:0] out_curve_value,
  output logic        [1:0]  out_status
);

  localparam int unsigned NQ    = 32 + FRAC_BITS;
  localparam int unsigned STEPS = 3;

  typedef struct packed {
    logic signed [31:0] v0;
    logic signed [31:0] s0;
    logic signed [31:0] s1;
    logic signed [32:0] dt;
    logic signed [32:0] diff;
    logic               tneg;
    logic               zero;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] v0;
    logic signed [32:0] diff;
    logic               zero;
  } coef_side_t;

  typedef struct packed {
    logic signed [63:0] t;
    logic signed [63:0] c2;
    logic signed [63:0] m0;
    logic signed [31:0] v0;
    logic               sat;
    logic               zero;
  } horner_side_t;

  assign busy = ~rst_n;

  // ---------------------------------------------------------------- stage 1
  logic               s1_vld_r;
  logic signed [32:0] s1_dt_r, s1_u_r, s1_diff_r;
  logic signed [31:0] s1_v0_r, s1_s0_r, s1_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_dt_r   <= {in_end_time[31], in_end_time} - {in_start_time[31], in_start_time};
    s1_u_r    <= {in_query_time[31], in_query_time} - {in_start_time[31], in_start_time};
    s1_diff_r <= {in_end_value[31], in_end_value} - {in_start_value[31], in_start_value};
    s1_v0_r   <= in_start_value;
    s1_s0_r   <= in_start_out_slope;
    s1_s1_r   <= in_end_in_slope;
  end

  // ---------------------------------------------------------------- stage 2
  logic        [32:0] u_neg, dt_neg;
  logic               s2_vld_r;
  logic        [31:0] s2_umag_r, s2_dmag_r;
  div_side_t          s2_side_r;

  assign u_neg  = 33'(-s1_u_r);
  assign dt_neg = 33'(-s1_dt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_umag_r      <= s1_u_r[32]  ? u_neg[31:0]  : s1_u_r[31:0];
    s2_dmag_r      <= s1_dt_r[32] ? dt_neg[31:0] : s1_dt_r[31:0];
    s2_side_r.v0   <= s1_v0_r;
    s2_side_r.s0   <= s1_s0_r;
    s2_side_r.s1   <= s1_s1_r;
    s2_side_r.dt   <= s1_dt_r;
    s2_side_r.diff <= s1_diff_r;
    s2_side_r.tneg <= s1_u_r[32] ^ s1_dt_r[32];
    s2_side_r.zero <= (s1_dt_r == '0);
  end

  // ------------------------------------------------- restoring divider
  // Each stage brings down one numerator bit and decides one quotient bit.
  // The numerator leaves the top of div_nq_r while quotient bits enter below.
  logic            div_vld_r  [NQ];
  logic [31:0]     div_rem_r  [NQ];
  logic [NQ-1:0]   div_nq_r   [NQ];
  logic [31:0]     div_den_r  [NQ];
  div_side_t       div_side_r [NQ];

  for (genvar i = 0; i < NQ; i++) begin : g_div
    logic            vld_in;
    logic [31:0]     rem_in, den_in;
    logic [NQ-1:0]   nq_in;
    div_side_t       side_in;
    logic [32:0]     trial;
    logic [33:0]     trial_sub;
    logic            ge;

    if (i == 0) begin : g_first
      assign vld_in  = s2_vld_r;
      assign rem_in  = '0;
      assign nq_in   = {s2_umag_r, {FRAC_BITS{1'b0}}};
      assign den_in  = s2_dmag_r;
      assign side_in = s2_side_r;
    end else begin : g_next
      assign vld_in  = div_vld_r[i-1];
      assign rem_in  = div_rem_r[i-1];
      assign nq_in   = div_nq_r[i-1];
      assign den_in  = div_den_r[i-1];
      assign side_in = div_side_r[i-1];
    end

    assign trial     = {rem_in, nq_in[NQ-1]};
    assign trial_sub = {1'b0, trial} - {2'b00, den_in};
    assign ge        = ~trial_sub[33];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[i] <= 1'b0;
      end else begin
        div_vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      div_rem_r[i]  <= ge ? trial_sub[31:0] : trial[31:0];
      div_nq_r[i]   <= {nq_in[NQ-2:0], ge};
      div_den_r[i]  <= den_in;
      div_side_r[i] <= side_in;
    end
  end

  // ------------------------------------------------- signed position
  logic        [63:0] tq;
  logic               t_vld_r;
  logic signed [63:0] t_r;
  div_side_t          t_side_r;

  assign tq = {{(64 - NQ){1'b0}}, div_nq_r[NQ-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= div_vld_r[NQ-1];
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= div_side_r[NQ-1].tneg ? $signed(64'(-tq)) : $signed(tq);
    t_side_r <= div_side_r[NQ-1];
  end

  // ------------------------------------------------- scaled tangents
  logic               m0_vld, m1_vld, m0_sat, m1_sat;
  logic signed [63:0] m0_p, m1_p;
  logic        [63:0] m0_t;
  coef_side_t         m1_side_in, m1_side_out;

  assign m1_side_in.v0   = t_side_r.v0;
  assign m1_side_in.diff = t_side_r.diff;
  assign m1_side_in.zero = t_side_r.zero;

  hse_mulq #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (64)
  ) u_mul_m0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (t_vld_r),
    .in_a     ({{32{t_side_r.s0[31]}}, t_side_r.s0}),
    .in_b     ({{31{t_side_r.dt[32]}}, t_side_r.dt}),
    .in_side  (t_r),
    .out_vld  (m0_vld),
    .out_p    (m0_p),
    .out_sat  (m0_sat),
    .out_side (m0_t)
  );

  hse_mulq #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    ($bits(coef_side_t))
  ) u_mul_m1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (t_vld_r),
    .in_a     ({{32{t_side_r.s1[31]}}, t_side_r.s1}),
    .in_b     ({{31{t_side_r.dt[32]}}, t_side_r.dt}),
    .in_side  (m1_side_in),
    .out_vld  (m1_vld),
    .out_p    (m1_p),
    .out_sat  (m1_sat),
    .out_side (m1_side_out)
  );

  // ------------------------------------------------- power-form coefficients
  // These sums cannot overflow 64 bits: the scaled tangents stay below 2^56.
  logic signed [63:0] diff64, c2_nxt, c3_nxt;
  logic               hs_vld_r  [STEPS+1];
  logic signed [63:0] hs_acc_r  [STEPS+1];
  horner_side_t       hs_side_r [STEPS+1];

  assign diff64 = {{31{m1_side_out.diff[32]}}, m1_side_out.diff};
  assign c2_nxt = (diff64 <<< 1) + diff64 - (m0_p <<< 1) - m1_p;
  assign c3_nxt = m0_p + m1_p - (diff64 <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_vld_r[0] <= 1'b0;
    end else begin
      hs_vld_r[0] <= m0_vld & m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    hs_acc_r[0]       <= c3_nxt;
    hs_side_r[0].t    <= $signed(m0_t);
    hs_side_r[0].c2   <= c2_nxt;
    hs_side_r[0].m0   <= m0_p;
    hs_side_r[0].v0   <= m1_side_out.v0;
    hs_side_r[0].sat  <= m0_sat | m1_sat;
    hs_side_r[0].zero <= m1_side_out.zero;
  end

  // ------------------------------------------------- Horner steps
  for (genvar k = 0; k < STEPS; k++) begin : g_horner
    logic               mul_vld, mul_sat, ovf;
    logic signed [63:0] mul_p, addend, sum_sat;
    logic        [64:0] sum;
    horner_side_t       mul_side, side_nxt;

    hse_mulq #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(horner_side_t))
    ) u_mul (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (hs_vld_r[k]),
      .in_a     (hs_acc_r[k]),
      .in_b     (hs_side_r[k].t),
      .in_side  (hs_side_r[k]),
      .out_vld  (mul_vld),
      .out_p    (mul_p),
      .out_sat  (mul_sat),
      .out_side (mul_side)
    );

    if (k == 0) begin : g_add_c2
      assign addend = mul_side.c2;
    end else if (k == 1) begin : g_add_m0
      assign addend = mul_side.m0;
    end else begin : g_add_v0
      assign addend = {{32{mul_side.v0[31]}}, mul_side.v0};
    end

    assign sum     = {mul_p[63], mul_p} + {addend[63], addend};
    assign ovf     = sum[64] ^ sum[63];
    assign sum_sat = ovf ? (sum[64] ? hse_pkg::S64_MIN : hse_pkg::S64_MAX)
                         : $signed(sum[63:0]);

    always_comb begin
      side_nxt     = mul_side;
      side_nxt.sat = mul_side.sat | mul_sat | ovf;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hs_vld_r[k+1] <= 1'b0;
      end else begin
        hs_vld_r[k+1] <= mul_vld;
      end
    end

    always_ff @(posedge clk) begin
      hs_acc_r[k+1]  <= sum_sat;
      hs_side_r[k+1] <= side_nxt;
    end
  end

  // ------------------------------------------------- narrowing and output
  logic signed [63:0]   acc;
  logic                 fits32;
  logic signed [31:0]   value_nxt;
  hse_pkg::status_t     status_nxt;
  logic                 out_valid_r;
  logic signed [31:0]   out_curve_value_r;
  hse_pkg::status_t     out_status_r;

  assign acc    = hs_acc_r[STEPS];
  assign fits32 = (&acc[63:31]) | ~(|acc[63:31]);

  always_comb begin
    if (hs_side_r[STEPS].zero) begin
      value_nxt  = hs_side_r[STEPS].v0;
      status_nxt = hse_pkg::STATUS_ZERO_INTERVAL;
    end else begin
      if (fits32) begin
        value_nxt = acc[31:0];
      end else begin
        value_nxt = acc[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      status_nxt = (hs_side_r[STEPS].sat | ~fits32) ? hse_pkg::STATUS_SATURATED
                                                     : hse_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hs_vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_curve_value_r <= value_nxt;
    out_status_r      <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_curve_value_r;
  assign out_status      = out_status_r;

endmodule

[sv/hse_checker.sv]
// Port-level checks for the Hermite segment evaluator, bound to its top level.
// Depends on hse_pkg and hermite_segment_evaluate.
module hse_checker #(
  parameter int unsigned FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_query_time,
  input logic signed [31:0] in_start_time,
  input logic signed [31:0] in_start_value,
  input logic signed [31:0] in_end_time,
  input logic               out_valid,
  input logic signed [31:0] out_curve_value,
  input logic        [1:0]  out_status
);

  // Front end, divider, position sign, tangent multipliers, coefficients,
  // three Horner steps and the output register.
  localparam int unsigned LATENCY = 2 + (32 + FRAC_BITS) + 1 + 5 + 1 + 3 * 6 + 1;

  logic accept;
  assign accept = start & ~busy;

  // Every accepted word yields exactly one result, a fixed time later.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("no result at the expected time after an accepted word");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching accepted word");

  // A zero-length interval returns the start value unchanged.
  a_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_start_time == in_end_time) |-> ##LATENCY
      (out_status == hse_pkg::STATUS_ZERO_INTERVAL &&
       out_curve_value == $past(in_start_value, LATENCY)))
    else $error("zero-length interval not reported with the start value");

  // Evaluating exactly at the first keyframe gives its value without saturation.
  a_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_query_time == in_start_time) && (in_start_time != in_end_time)
      |-> ##LATENCY
      (out_status == hse_pkg::STATUS_OK &&
       out_curve_value == $past(in_start_value, LATENCY)))
    else $error("query at the start time did not return the start value");

endmodule

bind hermite_segment_evaluate hse_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_hse_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_query_time      (in_query_time),
  .in_start_time      (in_start_time),
  .in_start_value     (in_start_value),
  .in_end_time        (in_end_time),
  .out_valid          (out_valid),
  .out_curve_value    (out_curve_value),
  .out_status         (out_status)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for hermite_segment_evaluate: a scoreboard class predicts
// each interpolated curve word and checks results in order. Needs hse_pkg and the DUT.
module testbench;

  localparam int unsigned FB = hse_pkg::FRAC_BITS_DEF;
  localparam int unsigned LATENCY = 60 + FB;
  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] query_time;
    logic signed [31:0] start_time;
    logic signed [31:0] start_value;
    logic signed [31:0] start_out_slope;
    logic signed [31:0] end_time;
    logic signed [31:0] end_value;
    logic signed [31:0] end_in_slope;
  } query_t;

  typedef struct {
    logic signed [31:0] curve_value;
    hse_pkg::status_t   status;
  } curve_t;

  class curve_scoreboard;
    curve_t      expected_curves[$];
    bit          clipped;
    int unsigned mismatches;
    int unsigned curves_checked;
    int unsigned zero_spans;
    int unsigned saturations;

    // Fixed-point product, rounded half away from zero, clamped to 64 bits.
    function logic signed [63:0] mul_q(input logic signed [63:0] a, input logic signed [63:0] b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] prod;
      logic [127:0] lim;
      bit           neg;
      neg  = a[63] ^ b[63];
      ua   = a[63] ? -a : a;
      ub   = b[63] ? -b : b;
      prod = (128'(ua) * 128'(ub) + (128'd1 << (FB - 1))) >> FB;
      lim  = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
      if (prod > lim) begin
        clipped = 1'b1;
        return neg ? hse_pkg::S64_MIN : hse_pkg::S64_MAX;
      end
      return neg ? -prod[63:0] : prod[63:0];
    endfunction

    function logic signed [63:0] add_q(input logic signed [63:0] a, input logic signed [63:0] b);
      logic [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) begin
        clipped = 1'b1;
        return sum[64] ? hse_pkg::S64_MIN : hse_pkg::S64_MAX;
      end
      return sum[63:0];
    endfunction

    function curve_t hermite_curve(input query_t q);
      logic signed [63:0] start_t;
      logic signed [63:0] v0;
      logic signed [63:0] span;
      logic signed [63:0] offset;
      logic signed [63:0] pos;
      logic signed [63:0] m0;
      logic signed [63:0] m1;
      logic signed [63:0] diff;
      logic signed [63:0] c2;
      logic signed [63:0] c3;
      logic signed [63:0] acc;
      logic signed [63:0] s0;
      logic signed [63:0] s1;
      logic signed [63:0] v1;
      logic [63:0]        mag_off;
      logic [63:0]        mag_span;
      logic [63:0]        frac;
      curve_t             c;
      start_t = q.start_time;
      v0      = q.start_value;
      v1      = q.end_value;
      s0      = q.start_out_slope;
      s1      = q.end_in_slope;
      span    = 64'(q.end_time) - start_t;
      if (span == 0) begin
        c.curve_value = q.start_value;
        c.status      = hse_pkg::STATUS_ZERO_INTERVAL;
        return c;
      end
      offset   = 64'(q.query_time) - start_t;
      mag_off  = offset[63] ? -offset : offset;
      mag_span = span[63] ? -span : span;
      frac     = (mag_off << FB) / mag_span;
      pos      = (offset[63] != span[63]) ? -frac : frac;
      clipped  = 1'b0;
      m0   = mul_q(s0, span);
      m1   = mul_q(s1, span);
      diff = v1 - v0;
      c2   = 3 * diff - 2 * m0 - m1;
      c3   = m0 + m1 - 2 * diff;
      // Power form, evaluated from the cubic term inwards.
      acc  = add_q(mul_q(c3, pos), c2);
      acc  = add_q(mul_q(acc, pos), m0);
      acc  = add_q(mul_q(acc, pos), v0);
      if (acc > 64'(Q_MAX)) begin
        acc     = 64'(Q_MAX);
        clipped = 1'b1;
      end else if (acc < 64'(Q_MIN)) begin
        acc     = 64'(Q_MIN);
        clipped = 1'b1;
      end
      c.curve_value = acc[31:0];
      c.status      = clipped ? hse_pkg::STATUS_SATURATED : hse_pkg::STATUS_OK;
      return c;
    endfunction

    function void note_query(input query_t q);
      expected_curves.push_back(hermite_curve(q));
    endfunction

    function void check_result(input logic signed [31:0] value, input logic [1:0] status);
      curve_t c;
      if (expected_curves.size() == 0) begin
        $error("result word with none expected: value %0d, status %0d", value, status);
        mismatches++;
        return;
      end
      c = expected_curves.pop_front();
      curves_checked++;
      if (c.status == hse_pkg::STATUS_ZERO_INTERVAL) zero_spans++;
      if (c.status == hse_pkg::STATUS_SATURATED) saturations++;
      if (value !== c.curve_value) begin
        $error("curve_value mismatch: expected %0d, got %0d", c.curve_value, value);
        mismatches++;
      end
      if (status !== c.status) begin
        $error("status mismatch: expected %0d (%s), got %0d", c.status, c.status.name(), status);
        mismatches++;
      end
    endfunction

    function int unsigned pending_count();
      return expected_curves.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_query_time;
  logic signed [31:0] in_start_time;
  logic signed [31:0] in_start_value;
  logic signed [31:0] in_start_out_slope;
  logic signed [31:0] in_end_time;
  logic signed [31:0] in_end_value;
  logic signed [31:0] in_end_in_slope;
  logic               out_valid;
  logic signed [31:0] out_curve_value;
  logic        [1:0]  out_status;

  curve_scoreboard board;
  int unsigned     cycle_count = 0;

  hermite_segment_evaluate #(
    .FRAC_BITS(FB)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_query_time     (in_query_time),
    .in_start_time     (in_start_time),
    .in_start_value    (in_start_value),
    .in_start_out_slope(in_start_out_slope),
    .in_end_time       (in_end_time),
    .in_end_value      (in_end_value),
    .in_end_in_slope   (in_end_in_slope),
    .out_valid         (out_valid),
    .out_curve_value   (out_curve_value),
    .out_status        (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Words are noted and results checked on the values held just before each rising edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_query('{in_query_time, in_start_time, in_start_value, in_start_out_slope,
                         in_end_time, in_end_value, in_end_in_slope});
    end
    if (rst_n && out_valid) begin
      board.check_result(out_curve_value, out_status);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic query_t segment(input logic signed [31:0] qt, input logic signed [31:0] t0,
                                     input logic signed [31:0] v0, input logic signed [31:0] s0,
                                     input logic signed [31:0] t1, input logic signed [31:0] v1,
                                     input logic signed [31:0] s1);
    query_t q;
    q = '{qt, t0, v0, s0, t1, v1, s1};
    return q;
  endfunction

  function automatic query_t random_query();
    query_t             q;
    logic signed [63:0] span;
    logic signed [63:0] pos;
    int unsigned        kind;
    q = segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      q.end_time = q.start_time;
    end else if (kind <= 2) begin
      // Tiny interval with random query: mostly far outside the segment.
      q.end_time = q.start_time + 32'($urandom_range(1, 16));
    end else if (kind >= 5) begin
      // A realistic keyframe pair, queried in or just around the segment.
      q.start_time = $signed($urandom) >>> 7;
      span = $urandom_range(1, 1 << 20);
      if ($urandom_range(0, 1) == 1) span = -span;
      q.end_time = q.start_time + span[31:0];
      pos = (span * ($signed($urandom_range(0, 96)) - 16)) / 64;
      q.query_time = q.start_time + pos[31:0];
      q.start_value = $signed($urandom) >>> 7;
      q.end_value = $signed($urandom) >>> 7;
      q.start_out_slope = $signed($urandom) >>> 13;
      q.end_in_slope = $signed($urandom) >>> 13;
    end
    return q;
  endfunction

  task automatic drive_query(input query_t q);
    in_query_time      = q.query_time;
    in_start_time      = q.start_time;
    in_start_value     = q.start_value;
    in_start_out_slope = q.start_out_slope;
    in_end_time        = q.end_time;
    in_end_value       = q.end_value;
    in_end_in_slope    = q.end_in_slope;
  endtask

  task automatic send_query(input query_t q);
    @(negedge clk);
    drive_query(q);
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    drive_query(random_query());
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    start = 1'b0;
    while (board.pending_count() != 0) @(negedge clk);
  endtask

  initial begin
    query_t directed[$];
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    drive_query(segment(0, 0, 0, 0, 0, 0, 0));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(segment(0, 0, Q_MAX, Q_MAX, 0, Q_MIN, Q_MIN));
    directed.push_back(segment(Q_MAX, Q_MIN, Q_MIN, 0, Q_MIN, 0, 0));
    directed.push_back(segment(0, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE));
    directed.push_back(segment(4 * Q_ONE, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE));
    directed.push_back(segment(2 * Q_ONE, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE));
    directed.push_back(segment(-2 * Q_ONE, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE));
    directed.push_back(segment(7 * Q_ONE, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE));
    directed.push_back(segment(Q_ONE, 4 * Q_ONE, Q_ONE, -Q_ONE, 0, 3 * Q_ONE, Q_ONE));
    directed.push_back(segment(0, Q_MIN, 0, Q_ONE, Q_MAX, Q_ONE, -Q_ONE));
    directed.push_back(segment(0, Q_MAX, Q_ONE, Q_ONE, Q_MIN, 0, Q_ONE));
    directed.push_back(segment(Q_MAX, 0, Q_MAX, Q_MAX, 1, Q_MAX, Q_MAX));
    directed.push_back(segment(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN + 1, Q_MIN, Q_MIN));
    directed.push_back(segment(Q_MAX, Q_MIN, 0, 0, Q_MIN + 1, Q_ONE, 0));
    directed.push_back(segment(-4 * Q_ONE, 0, 0, 0, 4 * Q_ONE, Q_MAX, 0));
    directed.push_back(segment(-4 * Q_ONE, 0, 0, 0, 4 * Q_ONE, Q_MIN, 0));
    directed.push_back(segment(2 * Q_ONE, 0, 0, Q_MAX, 4 * Q_ONE, 0, Q_MIN));
    directed.push_back(segment(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN));
    directed.push_back(segment(32'sh0000_8000, 0, -1, -1, 1, 1, -1));
    directed.push_back(segment(1, 0, Q_ONE, 0, 3, 0, 0));
    directed.push_back(segment(-1, -1, -1, -1, -2, -1, -1));
    foreach (directed[k]) send_query(directed[k]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3 || i == 2 * RANDOM_WORDS / 3) wait_for_drain();
      // Bursty idling in most stretches, none in every fourth and none near the end.
      if (i < RANDOM_WORDS - 200 && (i / 50) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 4));
      end
      send_query(random_query());
    end
    wait_for_drain();
    repeat (LATENCY + 20) @(posedge clk);

    $display("Checked %0d curve words: %0d zero-length intervals, %0d saturated.",
             board.curves_checked, board.zero_spans, board.saturations);
    $display("Stimulus: directed corner segments, then random keyframe pairs and noise.");
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
